// File: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the min-tracking stack
// Sizes, request and status codes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    // Stack geometry and word width.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);

    // Request codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;      // store a new top entry
        logic overflow;  // report a push on a full stack
        logic underflow; // report a pop on an empty stack
        logic pop_last;  // pop the only entry
        logic pop_read;  // pop and fetch the entry below from memory
        logic fill;      // load the fetched entry as the new top
    } t_cmd;

    // Occupancy status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl: controller for the min-tracking stack
// Decodes each request against the stack occupancy and sequences the
// memory read that a pop needs when entries remain below the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_req_type,
    input  wire mts_pkg::t_stat i_stat,
    output logic               o_busy,
    output mts_pkg::t_cmd      o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;
    logic w_push_req;
    logic w_pop_req;

    assign o_busy     = (r_state == ST_FILL);
    assign w_accept   = i_start && !o_busy;
    assign w_push_req = w_accept && (i_req_type == mts_pkg::REQ_PUSH);
    assign w_pop_req  = w_accept && (i_req_type == mts_pkg::REQ_POP);

    // Command decode for the accepted transaction.
    always_comb begin
        o_cmd.push      = w_push_req && !i_stat.full;
        o_cmd.overflow  = w_push_req && i_stat.full;
        o_cmd.underflow = w_pop_req && i_stat.empty;
        o_cmd.pop_last  = w_pop_req && !i_stat.empty && i_stat.one;
        o_cmd.pop_read  = w_pop_req && !i_stat.empty && !i_stat.one;
        o_cmd.fill      = (r_state == ST_FILL);
    end

    // Next state: a pop that leaves entries waits in the fill state for the read.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.pop_read) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp: datapath for the min-tracking stack
// Holds the entry count, the top entry in registers, the lower entries in a
// RAM, and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mts_pkg::t_cmd                         i_cmd,
    input  wire logic signed [mts_pkg::DATA_WIDTH-1:0] i_push_value,
    output mts_pkg::t_stat                             o_stat,
    output logic                                       o_valid,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_popped_value,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_popped_min,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_current_min,
    output logic                                       o_is_empty,
    output logic [1:0]                                 o_status
);

    localparam int W = mts_pkg::DATA_WIDTH;

    // Entry count and the cached top entry.
    logic [mts_pkg::CNT_W-1:0] r_count;
    logic [mts_pkg::CNT_W-1:0] n_count;
    logic signed [W-1:0]       r_top_val;
    logic signed [W-1:0]       n_top_val;
    logic signed [W-1:0]       r_top_min;
    logic signed [W-1:0]       n_top_min;

    // Result registers.
    logic                r_valid;
    logic                n_valid;
    logic signed [W-1:0] r_pop_val;
    logic signed [W-1:0] n_pop_val;
    logic signed [W-1:0] r_pop_min;
    logic signed [W-1:0] n_pop_min;
    logic signed [W-1:0] r_cur_min;
    logic signed [W-1:0] n_cur_min;
    logic                r_empty;
    logic                n_empty;
    logic [1:0]          r_status;
    logic [1:0]          n_status;

    logic [mts_pkg::CNT_W-1:0] w_cnt_m1;
    logic [mts_pkg::CNT_W-1:0] w_cnt_m2;
    logic signed [W-1:0]       w_new_min;
    logic [2*W-1:0]            w_rd_data;
    logic signed [W-1:0]       w_rd_val;
    logic signed [W-1:0]       w_rd_min;

    assign w_cnt_m1 = r_count - mts_pkg::CNT_W'(1);
    assign w_cnt_m2 = r_count - mts_pkg::CNT_W'(2);

    // Occupancy status for the controller.
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == mts_pkg::CNT_W'(mts_pkg::DEPTH));
    assign o_stat.one   = (r_count == mts_pkg::CNT_W'(1));

    // Running minimum of a new entry; a tie keeps the previous minimum.
    assign w_new_min = (o_stat.empty || (i_push_value < r_top_min)) ? i_push_value
                                                                   : r_top_min;

    // Entries below the top live in memory as {value, minimum}.
    mts_ram #(
        .WIDTH (2 * W),
        .DEPTH (mts_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push && !o_stat.empty),
        .i_wr_addr (w_cnt_m1[mts_pkg::ADDR_W-1:0]),
        .i_wr_data ({r_top_val, r_top_min}),
        .i_rd_en   (i_cmd.pop_read),
        .i_rd_addr (w_cnt_m2[mts_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_val = w_rd_data[2*W-1:W];
    assign w_rd_min = w_rd_data[W-1:0];

    // Next-state logic for the stack and the result.
    always_comb begin
        n_count   = r_count;
        n_top_val = r_top_val;
        n_top_min = r_top_min;
        n_valid   = 1'b0;
        n_pop_val = r_pop_val;
        n_pop_min = r_pop_min;
        n_cur_min = r_cur_min;
        n_empty   = r_empty;
        n_status  = r_status;

        if (i_cmd.push) begin
            n_count   = r_count + mts_pkg::CNT_W'(1);
            n_top_val = i_push_value;
            n_top_min = w_new_min;
            n_valid   = 1'b1;
            n_pop_val = '0;
            n_pop_min = '0;
            n_cur_min = w_new_min;
            n_empty   = 1'b0;
            n_status  = mts_pkg::STATUS_OK;
        end else if (i_cmd.overflow) begin
            n_valid   = 1'b1;
            n_pop_val = '0;
            n_pop_min = '0;
            n_cur_min = r_top_min;
            n_empty   = 1'b0;
            n_status  = mts_pkg::STATUS_OVERFLOW;
        end else if (i_cmd.underflow) begin
            n_valid   = 1'b1;
            n_pop_val = '0;
            n_pop_min = '0;
            n_cur_min = '0;
            n_empty   = 1'b1;
            n_status  = mts_pkg::STATUS_UNDERFLOW;
        end else if (i_cmd.pop_last) begin
            n_count   = '0;
            n_valid   = 1'b1;
            n_pop_val = r_top_val;
            n_pop_min = r_top_min;
            n_cur_min = '0;
            n_empty   = 1'b1;
            n_status  = mts_pkg::STATUS_OK;
        end else if (i_cmd.pop_read) begin
            // The result waits until the entry below has been read.
            n_count   = w_cnt_m1;
            n_pop_val = r_top_val;
            n_pop_min = r_top_min;
            n_empty   = 1'b0;
            n_status  = mts_pkg::STATUS_OK;
        end else if (i_cmd.fill) begin
            n_top_val = w_rd_val;
            n_top_min = w_rd_min;
            n_valid   = 1'b1;
            n_cur_min = w_rd_min;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        r_pop_val <= n_pop_val;
        r_pop_min <= n_pop_min;
        r_cur_min <= n_cur_min;
        r_empty   <= n_empty;
        r_status  <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_popped_value = r_pop_val;
    assign o_popped_min   = r_pop_min;
    assign o_current_min  = r_cur_min;
    assign o_is_empty     = r_empty;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// File: rtl/core/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack: bounded LIFO of signed words with running minimum
//
//   Channel   Direction  Handshake              Payload
//   request   in         start && !busy         i_req_type, i_push_value
//   result    out        o_valid (one cycle)    o_popped_value, o_popped_min,
//                                               o_current_min, o_is_empty,
//                                               o_status
//
// Every accepted transaction gives one result. A push, an overflow, an
// underflow or a pop of the last entry reports in the cycle after acceptance.
// A pop that leaves entries raises busy for one cycle while the RAM read of
// the new top completes, and reports once the fill state has loaded that top.
// Reset clears the entry count; the RAM needs no clearing pass.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  i_req_type,
    input  wire logic signed [mts_pkg::DATA_WIDTH-1:0] i_push_value,
    output logic                                       o_valid,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_popped_value,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_popped_min,
    output logic signed [mts_pkg::DATA_WIDTH-1:0]      o_current_min,
    output logic                                       o_is_empty,
    output logic [1:0]                                 o_status
);

    mts_pkg::t_cmd  w_cmd;
    mts_pkg::t_stat w_stat;

    // Request decode and sequencing.
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_busy     (busy),
        .o_cmd      (w_cmd)
    );

    // Stack storage and result registers.
    mts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_push_value   (i_push_value),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_popped_min   (o_popped_min),
        .o_current_min  (o_current_min),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

    // Busy always drops again in the cycle after it rises.
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A push transaction always reports in the next cycle.
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == mts_pkg::REQ_PUSH) |=> o_valid)
        else $error("push result missing");

    // A pop that waits for the read reports when the wait ends.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("pop result missing after read");

    // An empty stack reports a zero minimum.
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_current_min == '0))
        else $error("nonzero minimum on empty stack");

    // Underflow only happens on an empty stack.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mts_pkg::STATUS_UNDERFLOW) |-> o_is_empty)
        else $error("underflow reported on a non-empty stack");

endmodule

`default_nettype wire
